[rtl/core/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// Shared codes, widths and control types of the task scheduler table.
// ----------------------------------------------------------------------------
package tts_pkg;

	localparam int HANDLE_W   = 8;
	localparam int RUN_W      = 8;
	localparam int OUT_SLOT_W = 4;

	// command codes
	localparam logic [1:0] CMD_ADD      = 2'd0;
	localparam logic [1:0] CMD_DELETE   = 2'd1;
	localparam logic [1:0] CMD_TICK     = 2'd2;
	localparam logic [1:0] CMD_DISPATCH = 2'd3;

	// result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_EMPTY    = 2'd2;
	localparam logic [1:0] STATUS_NONE_DUE = 2'd3;

	// sticky error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_FULL   = 2'd1;
	localparam logic [1:0] ERR_DELETE = 2'd2;

	localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

	// verdict of the slot unit on one visited slot
	typedef struct packed {
		logic                we;      // write the new entry back
		logic                emit;    // this slot gives a result
		logic                found;   // add found its free slot
		logic [1:0]          status;
		logic [HANDLE_W-1:0] task_id;
	} slot_ctl_t;

endpackage

[rtl/core/tts_slot_mem.sv]
// ----------------------------------------------------------------------------
// tts_slot_mem
// Slot table memory: one write and one registered read port, with a valid
// bit per entry so that an entry never written reads as all zero.
// ----------------------------------------------------------------------------
module tts_slot_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3,
	parameter int W     = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0]     mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [W-1:0]     rd_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_valid_q <= valid_q[raddr];
			end
		end
	end

	assign rdata = rd_valid_q ? rd_q : '0;

endmodule

[rtl/core/tts_slot_unit.sv]
// ----------------------------------------------------------------------------
// tts_slot_unit
// Shared per-slot update unit: applies one command to one table entry.
// ----------------------------------------------------------------------------
module tts_slot_unit #(
	parameter int DW = 16
) (
	input  logic [1:0]                    op,
	input  logic [tts_pkg::HANDLE_W-1:0]  handle_in,
	input  logic [DW-1:0]                 delay_in,
	input  logic [DW-1:0]                 period_in,
	input  logic [tts_pkg::HANDLE_W-1:0]  e_handle,
	input  logic [DW-1:0]                 e_delay,
	input  logic [DW-1:0]                 e_period,
	input  logic [tts_pkg::RUN_W-1:0]     e_run,
	output logic [tts_pkg::HANDLE_W-1:0]  n_handle,
	output logic [DW-1:0]                 n_delay,
	output logic [DW-1:0]                 n_period,
	output logic [tts_pkg::RUN_W-1:0]     n_run,
	output tts_pkg::slot_ctl_t            ctl
);

	always_comb begin
		n_handle = e_handle;
		n_delay  = e_delay;
		n_period = e_period;
		n_run    = e_run;
		ctl      = '0;
		unique case (op)
			tts_pkg::CMD_ADD: begin
				if (e_handle == '0) begin
					n_handle   = handle_in;
					n_delay    = delay_in;
					n_period   = period_in;
					n_run      = '0;
					ctl.we     = 1'b1;
					ctl.emit   = 1'b1;
					ctl.found  = 1'b1;
					ctl.status = tts_pkg::STATUS_OK;
				end
			end
			tts_pkg::CMD_DELETE: begin
				n_handle   = '0;
				n_delay    = '0;
				n_period   = '0;
				n_run      = '0;
				ctl.we     = 1'b1;
				ctl.emit   = 1'b1;
				ctl.status = (e_handle == '0) ? tts_pkg::STATUS_EMPTY : tts_pkg::STATUS_OK;
			end
			tts_pkg::CMD_TICK: begin
				if (e_handle != '0) begin
					ctl.we = 1'b1;
					if (e_delay == '0) begin
						if (e_run != tts_pkg::RUN_MAX) begin
							n_run = e_run + 8'd1;
						end
						if (e_period != '0) begin
							n_delay = e_period;
						end
					end else begin
						n_delay = e_delay - DW'(1);
					end
				end
			end
			tts_pkg::CMD_DISPATCH: begin
				if (e_run != '0) begin
					ctl.we      = 1'b1;
					ctl.emit    = 1'b1;
					ctl.status  = tts_pkg::STATUS_OK;
					ctl.task_id = e_handle;
					n_run       = e_run - 8'd1;
					// drop one-shot tasks once fired
					if (e_period == '0) begin
						n_handle = '0;
						n_delay  = '0;
						n_period = '0;
						n_run    = '0;
					end
				end
			end
		endcase
	end

endmodule

[rtl/core/tick_task_scheduler_table.sv]
// ----------------------------------------------------------------------------
// tick_task_scheduler_table
// Time-triggered task table: add, delete, tick and dispatch commands.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): one item carries a command with its
//   operands. in_stall is high while an item is at work, so one item is taken
//   at a time.
//   Output channel (out_valid / out_stall): add, delete and tick give one
//   result item; dispatch gives one item per slot with a pending run, in slot
//   order, the final one marked by last (or a single nothing-due item).
//   Timing: add, tick and dispatch walk every slot through the shared slot
//   unit at one slot per cycle, as the single memory read port allows, while
//   no receiver stall holds the walk; each slot is read through the
//   registered read port ahead of the unit. Add stops early at the first
//   free slot. A delete visits only its given slot, or none if out of range.
//   Reset: every slot is free and the sticky error is cleared at once; no
//   clearing pass is run, valid bits in the memory stand in for it.
//   Receiver stall: the result register holds its item; the slot walk pauses
//   on the slot that wants to emit until the register is free.
// ----------------------------------------------------------------------------
module tick_task_scheduler_table #(
	parameter int MAX_TASKS   = 8,
	parameter int DELAY_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  task_handle,
	input  logic [15:0] delay,
	input  logic [15:0] period,
	input  logic [2:0]  slot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  slot_out,
	output logic [7:0]  task_out,
	output logic        last,
	output logic [1:0]  error_code
);

	localparam int DW = DELAY_WIDTH;
	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int HW = tts_pkg::HANDLE_W;
	localparam int RW = tts_pkg::RUN_W;
	localparam int EW = HW + DW + DW + RW;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]    st_q;

	// latched command
	logic [1:0]    op_q;
	logic [HW-1:0] handle_q;
	logic [DW-1:0] delay_q;
	logic [DW-1:0] period_q;
	logic [2:0]    slot_q;
	logic          del_oor_q;

	// walk control
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] end_q;
	logic          issue_q;
	logic          ex_valid_s1;
	logic [CW-1:0] ex_idx_s1;
	logic          found_q;
	logic          any_q;

	logic [1:0]         sticky_q;
	logic [MAX_TASKS-1:0] nz_q;

	// result register
	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [3:0]    slot_out_q;
	logic [7:0]    task_out_q;
	logic          last_q;
	logic [1:0]    err_out_q;

	logic          accept;
	logic          out_free;
	logic          out_load;
	logic          adv;
	logic          mem_re;
	logic          mem_we;
	logic [EW-1:0] rd_entry;
	logic [EW-1:0] wr_entry;

	logic [HW-1:0] e_handle, n_handle;
	logic [DW-1:0] e_delay, n_delay;
	logic [DW-1:0] e_period, n_period;
	logic [RW-1:0] e_run, n_run;
	tts_pkg::slot_ctl_t ctl;

	logic          s1_emit;
	logic          pend_above;
	logic          fin_need;
	logic          del_in_range;
	logic          issue_last;

	assign accept   = in_valid && (st_q == ST_IDLE);
	assign in_stall = (st_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign {e_handle, e_delay, e_period, e_run} = rd_entry;
	assign wr_entry = {n_handle, n_delay, n_period, n_run};

	assign s1_emit    = ex_valid_s1 && ctl.emit;
	assign adv        = !s1_emit || out_free;
	assign mem_re     = (st_q == ST_WALK) && adv && issue_q;
	assign mem_we     = (st_q == ST_WALK) && adv && ex_valid_s1 && ctl.we;
	assign issue_last = (CW'(rd_idx_q + 1'b1) == end_q);
	assign del_in_range = (32'(slot) < MAX_TASKS);

	// a result enters the register from the walk or from the closing step
	assign out_load = ((st_q == ST_WALK) && adv && s1_emit) ||
	                  ((st_q == ST_FIN) && fin_need && out_free);

	// pending runs in slots beyond the one at work decide the last flag
	always_comb begin
		pend_above = 1'b0;
		for (int j = 0; j < MAX_TASKS; j++) begin
			if ((CW'(j) > ex_idx_s1) && nz_q[j]) begin
				pend_above = 1'b1;
			end
		end
	end

	always_comb begin
		case (op_q)
			tts_pkg::CMD_ADD:      fin_need = !found_q;
			tts_pkg::CMD_DELETE:   fin_need = del_oor_q;
			tts_pkg::CMD_TICK:     fin_need = 1'b1;
			default:               fin_need = !any_q;
		endcase
	end

	tts_slot_mem #(
		.DEPTH (MAX_TASKS),
		.AW    (AW),
		.W     (EW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (ex_idx_s1[AW-1:0]),
		.wdata  (wr_entry),
		.re     (mem_re),
		.raddr  (rd_idx_q[AW-1:0]),
		.rdata  (rd_entry)
	);

	tts_slot_unit #(
		.DW (DW)
	) u_unit (
		.op        (op_q),
		.handle_in (handle_q),
		.delay_in  (delay_q),
		.period_in (period_q),
		.e_handle  (e_handle),
		.e_delay   (e_delay),
		.e_period  (e_period),
		.e_run     (e_run),
		.n_handle  (n_handle),
		.n_delay   (n_delay),
		.n_period  (n_period),
		.n_run     (n_run),
		.ctl       (ctl)
	);

	// command latch: payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= cmd;
			handle_q <= task_handle;
			delay_q  <= DW'(delay);
			period_q <= DW'(period);
			slot_q   <= slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			del_oor_q   <= 1'b0;
			rd_idx_q    <= '0;
			end_q       <= '0;
			issue_q     <= 1'b0;
			ex_valid_s1 <= 1'b0;
			ex_idx_s1   <= '0;
			found_q     <= 1'b0;
			any_q       <= 1'b0;
			sticky_q    <= tts_pkg::ERR_NONE;
			nz_q        <= '0;
			out_valid_q <= 1'b0;
			status_q    <= tts_pkg::STATUS_OK;
			slot_out_q  <= '0;
			task_out_q  <= '0;
			last_q      <= 1'b0;
			err_out_q   <= tts_pkg::ERR_NONE;
		end else begin
			// load a new result, or drop the one just taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						st_q        <= ST_WALK;
						found_q     <= 1'b0;
						any_q       <= 1'b0;
						ex_valid_s1 <= 1'b0;
						del_oor_q   <= (cmd == tts_pkg::CMD_DELETE) && !del_in_range;
						if (cmd == tts_pkg::CMD_DELETE) begin
							rd_idx_q  <= CW'(slot);
							end_q     <= CW'(32'(slot) + 1);
							issue_q   <= del_in_range;
						end else begin
							rd_idx_q <= '0;
							end_q    <= CW'(MAX_TASKS);
							issue_q  <= 1'b1;
						end
					end
				end

				ST_WALK: begin
					if (adv) begin
						if (ex_valid_s1 && ctl.found) begin
							// first free slot taken: stop the walk
							found_q     <= 1'b1;
							issue_q     <= 1'b0;
							ex_valid_s1 <= 1'b0;
						end else if (issue_q) begin
							// advance the read stage
							ex_valid_s1 <= 1'b1;
							ex_idx_s1   <= rd_idx_q;
							rd_idx_q    <= CW'(rd_idx_q + 1'b1);
							if (issue_last) begin
								issue_q <= 1'b0;
							end
						end else begin
							ex_valid_s1 <= 1'b0;
						end

						if (ex_valid_s1) begin
							if (ctl.we) begin
								nz_q[ex_idx_s1[AW-1:0]] <= (n_run != '0);
							end
							if ((op_q == tts_pkg::CMD_DELETE) &&
							    (ctl.status == tts_pkg::STATUS_EMPTY)) begin
								sticky_q <= tts_pkg::ERR_DELETE;
							end
							if (ctl.emit) begin
								any_q       <= 1'b1;
								status_q    <= ctl.status;
								slot_out_q  <= 4'(ex_idx_s1);
								task_out_q  <= ctl.task_id;
								last_q      <= (op_q == tts_pkg::CMD_DISPATCH) ? !pend_above
								               : 1'b1;
								if ((op_q == tts_pkg::CMD_DELETE) &&
								    (ctl.status == tts_pkg::STATUS_EMPTY)) begin
									err_out_q <= tts_pkg::ERR_DELETE;
								end else begin
									err_out_q <= sticky_q;
								end
							end
						end
					end
					if (!issue_q && !ex_valid_s1) begin
						st_q <= ST_FIN;
					end
				end

				ST_FIN: begin
					if (!fin_need) begin
						st_q <= ST_IDLE;
					end else if (out_free) begin
						st_q        <= ST_IDLE;
						task_out_q  <= '0;
						last_q      <= 1'b1;
						case (op_q)
							tts_pkg::CMD_ADD: begin
								status_q   <= tts_pkg::STATUS_FULL;
								slot_out_q <= 4'(MAX_TASKS);
								sticky_q   <= tts_pkg::ERR_FULL;
								err_out_q  <= tts_pkg::ERR_FULL;
							end
							tts_pkg::CMD_DELETE: begin
								status_q   <= tts_pkg::STATUS_EMPTY;
								slot_out_q <= {1'b0, slot_q};
								sticky_q   <= tts_pkg::ERR_DELETE;
								err_out_q  <= tts_pkg::ERR_DELETE;
							end
							tts_pkg::CMD_TICK: begin
								status_q   <= tts_pkg::STATUS_OK;
								slot_out_q <= '0;
								err_out_q  <= sticky_q;
							end
							default: begin
								status_q   <= tts_pkg::STATUS_NONE_DUE;
								slot_out_q <= '0;
								err_out_q  <= sticky_q;
							end
						endcase
					end
				end

				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot_out   = slot_out_q;
	assign task_out   = task_out_q;
	assign last       = last_q;
	assign error_code = err_out_q;

endmodule
